/* src/ppig_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the polar palette index generator.
package ppig_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int SQRT_STEPS       = 15;

    localparam int CFG_W   = 11;
    localparam int PIX_W   = 10;
    localparam int IDX_W   = 5;
    localparam int DELTA_W = 12;
    localparam int SQ_W    = 23;
    localparam int RAD_W   = 22;
    localparam int IN_SHIFT = 20;
    localparam int XY_W    = 36;
    localparam int Z_W     = 26;
    localparam int RADICAND_W = 30;
    localparam int REM_W   = 17;
    localparam int ROOT_W  = 15;
    localparam int ATERM_W = 13;
    localparam int PAL_MOD = 31;

    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(8388608);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                         in_disc;
        logic signed [XY_W-1:0]       x;
        logic signed [XY_W-1:0]       y;
        logic signed [Z_W-1:0]        z;
        logic [RADICAND_W-1:0]        v;
        logic [REM_W-1:0]             rem;
        logic [ROOT_W-1:0]            root;
    } iter_t;

    // Arctangent of 2^-k in turns scaled by 2^24, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_turn(input int k);
        logic signed [Z_W-1:0] r;
        begin
            unique case (k)
                0:  r = Z_W'(2097152);
                1:  r = Z_W'(1238021);
                2:  r = Z_W'(654136);
                3:  r = Z_W'(332050);
                4:  r = Z_W'(166669);
                5:  r = Z_W'(83416);
                6:  r = Z_W'(41718);
                7:  r = Z_W'(20860);
                8:  r = Z_W'(10430);
                9:  r = Z_W'(5215);
                10: r = Z_W'(2608);
                11: r = Z_W'(1304);
                12: r = Z_W'(652);
                13: r = Z_W'(326);
                14: r = Z_W'(163);
                15: r = Z_W'(81);
                16: r = Z_W'(41);
                17: r = Z_W'(20);
                18: r = Z_W'(10);
                19: r = Z_W'(5);
                20: r = Z_W'(3);
                21: r = Z_W'(1);
                22: r = Z_W'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* src/ppig_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and palette index results.
interface ppig_pixel_if
    import ppig_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ppig_index_if
    import ppig_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] palette_index;

    modport source (output valid, output palette_index, input ready);
    modport sink   (input valid, input palette_index, output ready);
endinterface

/* src/ppig_iter.sv */
`timescale 1ns / 1ps
// One pipeline stage: a CORDIC vectoring step and/or a square root digit step, each enabled by a parameter.
module ppig_iter
    import ppig_pkg::*;
#(
    parameter int STEP      = 0,
    parameter bit DO_CORDIC = 1'b1,
    parameter bit DO_SQRT   = 1'b1
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  iter_t in_data,
    output logic  out_valid,
    output iter_t out_data
);

    logic  valid_reg;
    iter_t data_reg;
    iter_t data_next;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic [REM_W+1:0]       rem_sh;
    logic [REM_W+1:0]       trial;

    always_comb
    begin
        data_next = in_data;
        xs = in_data.x >>> STEP;
        ys = in_data.y >>> STEP;
        rem_sh = {in_data.rem, in_data.v[RADICAND_W-1 -: 2]};
        trial  = {2'b00, in_data.root, 2'b01};
        if (DO_CORDIC)
        begin
            if (in_data.y > 0)
            begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + atan_turn(STEP);
            end
            else if (in_data.y < 0)
            begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - atan_turn(STEP);
            end
        end
        if (DO_SQRT)
        begin
            data_next.v = {in_data.v[RADICAND_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                data_next.rem  = REM_W'(rem_sh - trial);
                data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem  = REM_W'(rem_sh);
                data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/polar_palette_index_generator.sv */
`timescale 1ns / 1ps
// Top level of the polar palette index generator: a fully pipelined pixel-to-index datapath.
// Each accepted request passes stages A, B and C, the iteration stages, then F and G.
// Throughput: one request per cycle unless the output stalls; the depth is set by the longer
// of the CORDIC and square root digit chains, each step holding one register stage.
// A stalled output freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset clears all valid bits and sets image_width and image_height to 256.
module polar_palette_index_generator
    import ppig_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ppig_pixel_if.sink       pixel,
    ppig_index_if.source     palette
);

    // Number of iteration stages covers both the CORDIC and the square root.
    localparam int NS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    // Config registers: the user changes them only while the pipeline is empty; unchecked.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // The pipeline advances as a whole whenever the output register is free or
    // being emptied this cycle.
    logic valid_g_reg;
    logic adv;

    assign adv         = !valid_g_reg || palette.ready;
    assign pixel.ready = adv;

    // Stage A: offsets from the centre in half-pixel units, then the CORDIC
    // pre-rotation into the right half plane. Squares are unchanged by it.
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      valid_a_reg;
    logic signed [DELTA_W-1:0] dxa_reg;
    logic signed [DELTA_W-1:0] dya_reg;
    logic signed [Z_W-1:0]     z0_reg;

    assign dx = $signed({1'b0, pixel.pixel_x, 1'b0}) - $signed({1'b0, width_reg});
    assign dy = $signed({1'b0, pixel.pixel_y, 1'b0}) - $signed({1'b0, height_reg});

    // Stage B: the three squares.
    logic              valid_b_reg;
    logic [RAD_W-1:0]  sqx_reg;
    logic [RAD_W-1:0]  sqy_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic signed [DELTA_W-1:0] dxb_reg;
    logic signed [DELTA_W-1:0] dyb_reg;
    logic signed [Z_W-1:0]     zb_reg;

    // Stage C: sum of squares, disc test, and the first iteration state.
    logic              valid_c_reg;
    iter_t             iter_c_reg;
    logic [SQ_W-1:0]   sq;

    assign sq = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= pixel.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dx < 0)
            begin
                dxa_reg <= -dx;
                dya_reg <= -dy;
                z0_reg  <= (dy >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                dxa_reg <= dx;
                dya_reg <= dy;
                z0_reg  <= '0;
            end

            sqx_reg <= RAD_W'(dxa_reg * dxa_reg);
            sqy_reg <= RAD_W'(dya_reg * dya_reg);
            rad_reg <= RAD_W'(width_reg * width_reg);
            dxb_reg <= dxa_reg;
            dyb_reg <= dya_reg;
            zb_reg  <= z0_reg;

            iter_c_reg.in_disc <= sq < SQ_W'(rad_reg);
            iter_c_reg.x       <= XY_W'(dxb_reg) <<< IN_SHIFT;
            iter_c_reg.y       <= XY_W'(dyb_reg) <<< IN_SHIFT;
            iter_c_reg.z       <= zb_reg;
            iter_c_reg.v       <= {sq[RAD_W-1:0], 8'h00};
            iter_c_reg.rem     <= '0;
            iter_c_reg.root    <= '0;
        end
    end

    // Iteration stages: CORDIC step k and square root digit k side by side.
    logic  stage_valid [NS+1];
    iter_t stage_data  [NS+1];

    assign stage_valid[0] = valid_c_reg;
    assign stage_data[0]  = iter_c_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        ppig_iter #(
            .STEP      (k),
            .DO_CORDIC (k < CORDIC_STEPS),
            .DO_SQRT   (k < SQRT_STEPS)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // Stage F: clamp the angle to one half turn each way, and map -pi..pi onto
    // 0..31 with eight fractional bits: ((z + half) * 31) >> 16.
    iter_t                  last;
    logic signed [Z_W-1:0]  z_clamped;
    logic [Z_W-1:0]         z_off;
    logic [Z_W+4:0]         z_x31;
    logic                   valid_f_reg;
    logic                   in_disc_f_reg;
    logic [ROOT_W-1:0]      dterm_reg;
    logic [ATERM_W-1:0]     aterm_reg;

    assign last = stage_data[NS];

    always_comb
    begin
        if (last.z > HALF_TURN)
            z_clamped = HALF_TURN;
        else if (last.z < -HALF_TURN)
            z_clamped = -HALF_TURN;
        else
            z_clamped = last.z;
        z_off = Z_W'(z_clamped + HALF_TURN);
        z_x31 = ({z_off, 5'b00000}) - (Z_W+5)'(z_off);
    end

    // Stage G: sum the terms, keep the integer part, reduce it modulo 31 and add one.
    // Since 32 is 1 modulo 31, the high bits fold onto the low five.
    logic [ROOT_W:0]  sum;
    logic [7:0]       whole;
    logic [5:0]       folded;
    logic [IDX_W-1:0] residue;
    logic [IDX_W-1:0] index_g_reg;

    assign sum    = (ROOT_W+1)'(dterm_reg) + (ROOT_W+1)'(aterm_reg);
    assign whole  = sum[ROOT_W:8];
    assign folded = 6'(whole[7:5]) + 6'(whole[4:0]);
    assign residue = (folded >= 6'(PAL_MOD)) ? IDX_W'(folded - 6'(PAL_MOD))
                                             : IDX_W'(folded);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_f_reg <= stage_valid[NS];
            valid_g_reg <= valid_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_disc_f_reg <= last.in_disc;
            dterm_reg     <= last.root;
            aterm_reg     <= ATERM_W'(z_x31 >> 16);
            index_g_reg   <= in_disc_f_reg ? IDX_W'(residue + IDX_W'(1)) : '0;
        end
    end

    assign palette.valid         = valid_g_reg;
    assign palette.palette_index = index_g_reg;

    // The angle term never exceeds 31 in its integer part.
    a_aterm_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_f_reg && in_disc_f_reg |-> aterm_reg <= ATERM_W'(7936))
        else $error("angle term out of range");

    // The digit-by-digit root leaves a remainder of at most twice the root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NS] && last.in_disc
            |-> (ROOT_W+2)'(last.rem) <= ((ROOT_W+2)'(last.root) << 1))
        else $error("square root remainder too large");

    // The accumulated angle stays well inside the accumulator.
    a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NS] |-> (last.z < (HALF_TURN <<< 1)) && (last.z > -(HALF_TURN <<< 1)))
        else $error("CORDIC angle overflow");

    // The folded residue is a proper value modulo 31.
    a_residue: assert property (@(posedge clk) disable iff (!rst_n)
        valid_f_reg |-> residue < IDX_W'(PAL_MOD))
        else $error("modulo reduction failed");

endmodule

/* test/polar_palette_index_generator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the polar palette index generator.
module polar_palette_index_generator_test;
    import ppig_pkg::*;

    // Scoreboard: predicts the palette index of each accepted pixel request
    // and checks results in order against those predictions.
    class palette_scoreboard;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [IDX_W-1:0] pending[$];
        int errors;
        int checked;

        function new();
            width = 11'd256;
            height = 11'd256;
            errors = 0;
            checked = 0;
        endfunction

        // Arctangent of 2^-k in turns times 2^24, rounded to nearest.
        function longint atan_step(int k);
            longint tbl[24];
            tbl = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                    10430, 5215, 2608, 1304, 652, 326, 163, 81,
                    41, 20, 10, 5, 3, 1, 1, 0};
            return tbl[k];
        endfunction

        // The >>> operator on a signed longint floors, as the datapath does.
        function longint polar_angle(longint dx, longint dy);
            longint x, y, z, xs, ys;
            int k;
            x = dx <<< IN_SHIFT;
            y = dy <<< IN_SHIFT;
            z = 0;
            if (dx == 0 && dy == 0)
                return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? 64'sd8388608 : -64'sd8388608;
                x = -x;
                y = -y;
            end
            for (k = 0; k < CORDIC_STEPS_DEF; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z += atan_step(k);
                end
                else if (y < 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z -= atan_step(k);
                end
            end
            if (z > 8388608)
                z = 8388608;
            if (z < -8388608)
                z = -8388608;
            return z;
        endfunction

        function longint root_floor(longint v);
            longint r, b;
            r = 0;
            for (b = 64'sd1 << 30; b > 0; b = b >> 1)
                if ((r + b) * (r + b) <= v)
                    r = r + b;
            return r;
        endfunction

        function void note_request(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            longint dx, dy, sq, dist_term, ang_term, whole;
            dx = 2 * longint'(px) - longint'(width);
            dy = 2 * longint'(py) - longint'(height);
            sq = dx * dx + dy * dy;
            if (sq >= longint'(width) * longint'(width))
                pending.push_back('0);
            else
            begin
                dist_term = root_floor(sq << 8);
                ang_term = ((polar_angle(dx, dy) + 8388608) * 31) >> 16;
                whole = (dist_term + ang_term) >> 8;
                pending.push_back(IDX_W'(1 + whole % PAL_MOD));
            end
        endfunction

        function void check_index(logic [IDX_W-1:0] actual);
            logic [IDX_W-1:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected palette index %0d", $time, actual);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want !== actual)
            begin
                $display("%0t: palette_index mismatch expected %0d actual %0d",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    ppig_pixel_if pixel ();
    ppig_index_if palette ();

    polar_palette_index_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pixel.sink),
        .palette(palette.source)
    );

    always #5 clk = ~clk;

    palette_scoreboard board = new();
    bit calm;                 // set in the last part of the run: no idling at all
    longint cycle_count;
    int phases;

    initial
    begin
        pixel.valid = 1'b0;
        pixel.pixel_x = '0;
        pixel.pixel_y = '0;
        palette.ready = 1'b0;
    end

    // Requests are sampled at the rising edge where valid and ready are both
    // high; the scoreboard notes each one there, so the prediction always uses
    // the registers as they stand at acceptance.
    always @(posedge clk)
    begin
        if (rst_n && pixel.valid && pixel.ready)
            board.note_request(pixel.pixel_x, pixel.pixel_y);
        if (rst_n && palette.valid && palette.ready)
            board.check_index(palette.palette_index);
    end

    // The result side stalls in random bursts, except in the calm last part.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                palette.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(negedge clk);
            end
            palette.ready <= 1'b1;
        end
    end

    // Cycle limit: the slowest correct run has each request behind the longest
    // sender gap and the longest result stall plus the pipeline depth; this
    // allows several times that.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL polar_palette_index_generator");
            $finish;
        end
    end

    // Sends one pixel request and holds it until the block takes it.
    // The sender may idle first for a random burst.
    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        int n;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            pixel.valid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clk);
        end
        pixel.valid <= 1'b1;
        pixel.pixel_x <= px;
        pixel.pixel_y <= py;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every predicted index has arrived, then lets the pipeline
    // drain for its full depth so that the block is idle.
    task automatic drain_pipeline();
        pixel.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Registers are only written while the pipeline is empty.
    task automatic write_register(cfg_reg_t which, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == REG_IMAGE_WIDTH)
            board.width = value;
        else
            board.height = value;
        @(negedge clk);
    endtask

    // Pixels mostly inside or near the disc so that the CORDIC path is
    // exercised; a share covers the whole 10-bit range.
    task automatic random_pixels(int count);
        int i;
        int w, h;
        logic [PIX_W-1:0] px, py;
        w = int'(board.width);
        h = int'(board.height);
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0 || w == 0)
            begin
                px = PIX_W'($urandom);
                py = PIX_W'($urandom);
            end
            else
            begin
                px = PIX_W'($urandom_range(0, (w + 1) / 2 + w / 2));
                py = PIX_W'((h / 2) - (w / 2) + $urandom_range(0, w));
            end
            send_pixel(px, py);
        end
    endtask

    initial
    begin
        calm = 1'b0;
        cycle_count = 0;
        phases = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset sizes, centre pixel, negative x axis, corners,
        // field extremes, axis points.
        send_pixel(10'd128, 10'd128);
        send_pixel(10'd0, 10'd128);
        send_pixel(10'd1, 10'd128);
        send_pixel(10'd255, 10'd128);
        send_pixel(10'd128, 10'd1);
        send_pixel(10'd128, 10'd255);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd127, 10'd129);
        send_pixel(10'd129, 10'd127);
        send_pixel(10'd170, 10'd170);
        send_pixel(10'd40, 10'd60);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain_pipeline();

        // Zero width: everything outside. Then the extremes of both registers.
        write_register(REG_IMAGE_WIDTH, 11'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd5, 10'd9);
        drain_pipeline();
        write_register(REG_IMAGE_WIDTH, 11'd2047);
        write_register(REG_IMAGE_HEIGHT, 11'd2047);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd600);
        drain_pipeline();

        // Random phases across a spread of sizes, the smallest nonzero one among them.
        // The sender pauses for the pipeline to empty between phases.
        for (phases = 0; phases < 9; phases++)
        begin
            unique case (phases)
                0:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd1);
                    write_register(REG_IMAGE_HEIGHT, 11'd1);
                end
                1:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd1024);
                    write_register(REG_IMAGE_HEIGHT, 11'd1024);
                end
                2:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd256);
                    write_register(REG_IMAGE_HEIGHT, 11'd100);
                end
                3:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd37);
                    write_register(REG_IMAGE_HEIGHT, 11'd1024);
                end
                4:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd640);
                    write_register(REG_IMAGE_HEIGHT, 11'd480);
                end
                5:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'd2);
                    write_register(REG_IMAGE_HEIGHT, 11'd7);
                end
                6:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'h555);
                    write_register(REG_IMAGE_HEIGHT, 11'h2AA);
                end
                7:
                begin
                    write_register(REG_IMAGE_WIDTH, 11'h2AA);
                    write_register(REG_IMAGE_HEIGHT, 11'h555);
                end
                default:
                begin
                    write_register(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, 1024)));
                    write_register(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 1024)));
                    calm = 1'b1;
                end
            endcase
            random_pixels(100);
            drain_pipeline();
        end

        $display("Covered directed extremes, zero and maximum sizes, and %0d random phases;",
                 phases);
        $display("%0d palette indices were checked.", board.checked);
        if (board.errors == 0)
            $display("PASS polar_palette_index_generator");
        else
            $display("FAIL polar_palette_index_generator");
        $finish;
    end
endmodule

/* files.f */
src/ppig_pkg.sv
src/ppig_if.sv
src/ppig_iter.sv
src/polar_palette_index_generator.sv
test/polar_palette_index_generator_test.sv
